@@ src/tep_pkg.sv @@
// Shared types and constants for the timed event priority scheduler.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tep_pkg;
    localparam int unsigned QUEUE_DEPTH_DEF  = 16;
    localparam int unsigned CANCEL_DEPTH_DEF = 16;
    localparam int unsigned MAX_RESULTS_DEF  = 64;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [2:0] KIND_FIRED       = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED    = 3'd1;
    localparam logic [2:0] KIND_QUEUE_FULL  = 3'd2;
    localparam logic [2:0] KIND_ZERO_ID     = 3'd3;
    localparam logic [2:0] KIND_CANCEL_FULL = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE   = 3'd5;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] id;
        logic [31:0] interval;
        logic [15:0] stamp;
    } tep_entry_t;
endpackage
`default_nettype wire

@@ src/tep_queue_ram.sv @@
// Event store: single write port, single registered read port.
// Depends on tep_pkg for the entry type.
`default_nettype none
module tep_queue_ram import tep_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(QUEUE_DEPTH_DEF)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire tep_entry_t    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output tep_entry_t         rd_data
);
    tep_entry_t mem [DEPTH];
    tep_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

@@ src/tep_cancel_store.sv @@
// Cancel marks: id memory with registered read, valid flags in flip-flops,
// and a first-free-slot encoder. Depends on tep_pkg.
`default_nettype none
module tep_cancel_store import tep_pkg::*; #(
    parameter int unsigned DEPTH = CANCEL_DEPTH_DEF,
    parameter int unsigned AW    = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_id,
    output logic               rd_valid,
    input  wire logic          set_en,
    input  wire logic [AW-1:0] set_addr,
    input  wire logic [31:0]   set_id,
    input  wire logic          clr_en,
    input  wire logic [AW-1:0] clr_addr,
    output logic               free_any,
    output logic [AW-1:0]      free_addr
);
    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [31:0]      rd_id_reg;
    logic             rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (set_en) begin
            valid_next[set_addr] = 1'b1;
        end
        if (clr_en) begin
            valid_next[clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (set_en) begin
            mem[set_addr] <= set_id;
        end
        if (rd_en) begin
            rd_id_reg    <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_comb begin
        free_any  = 1'b0;
        free_addr = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any  = 1'b1;
                free_addr = AW'(i);
            end
        end
    end

    assign rd_id    = rd_id_reg;
    assign rd_valid = rd_valid_reg;
endmodule
`default_nettype wire

@@ src/timed_event_priority_scheduler.sv @@
// Timed event scheduler: control sequencer over the event store and cancel marks.
// Depends on tep_pkg, tep_queue_ram and tep_cancel_store.
// One item is handled at a time. A schedule shifts back, one by one, the queued events
// with a later due time in the sorted store, then writes the new event into the gap.
// A cancel sweeps the cancel memory slot by slot, reading each slot and then comparing it.
// A tick pops due events from the head; each popped event takes the cancel sweep and,
// for a periodic event, a re-insert. Each memory has a single read port.
// Results wait in an output register, so a stalled result channel only holds the step
// that produces the next result.
`default_nettype none
module timed_event_priority_scheduler import tep_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH          = QUEUE_DEPTH_DEF,
    parameter int unsigned CANCEL_DEPTH         = CANCEL_DEPTH_DEF,
    parameter int unsigned MAX_RESULTS_PER_TICK = MAX_RESULTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [31:0] s_event_id,
    input  wire logic [31:0] s_due_time,
    input  wire logic [31:0] s_repeat_interval,
    input  wire logic [31:0] s_current_time,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_result_kind,
    output logic [31:0]      m_fired_id,
    output logic [31:0]      m_fired_time,
    output logic             m_last
);
    localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW  = QCW + 1;
    localparam int unsigned CW  = (CANCEL_DEPTH > 1) ? $clog2(CANCEL_DEPTH) : 1;
    localparam int unsigned NW  = $clog2(MAX_RESULTS_PER_TICK);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_IREAD  = 4'd2;
    localparam logic [3:0] ST_ICMP   = 4'd3;
    localparam logic [3:0] ST_CREAD  = 4'd4;
    localparam logic [3:0] ST_CCMP   = 4'd5;
    localparam logic [3:0] ST_THEAD  = 4'd6;
    localparam logic [3:0] ST_THCHK  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     ret_reg, ret_next;
    logic [1:0]     op_reg, op_next;
    logic [31:0]    id_reg, id_next;
    logic [31:0]    due_reg, due_next;
    logic [31:0]    iv_reg, iv_next;
    logic [31:0]    now_reg, now_next;
    logic [QW-1:0]  head_reg, head_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [15:0]    stamp_reg, stamp_next;
    logic [QCW-1:0] pos_reg, pos_next;
    logic [31:0]    ins_id_reg, ins_id_next;
    logic [31:0]    ins_t_reg, ins_t_next;
    logic [31:0]    ins_iv_reg, ins_iv_next;
    logic [31:0]    ev_id_reg, ev_id_next;
    logic [31:0]    ev_t_reg, ev_t_next;
    logic [31:0]    ev_iv_reg, ev_iv_next;
    logic [CW-1:0]  cidx_reg, cidx_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [2:0]     em_kind_reg, em_kind_next;
    logic [31:0]    em_id_reg, em_id_next;
    logic [31:0]    em_time_reg, em_time_next;
    logic           em_last_reg, em_last_next;
    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_kind_reg, m_kind_next;
    logic [31:0]    m_id_reg, m_id_next;
    logic [31:0]    m_time_reg, m_time_next;
    logic           m_last_reg, m_last_next;

    logic          q_wr_en, q_rd_en;
    logic [QW-1:0] q_wr_addr, q_rd_addr;
    tep_entry_t    q_wr_data, q_rd_data;
    logic          c_rd_en, c_set_en, c_clr_en, c_rd_valid, c_free_any;
    logic [CW-1:0] c_set_addr, c_clr_addr, c_free_addr;
    logic [31:0]   c_rd_id, c_key;
    logic [32:0]   sat_sum;
    logic          c_hit;

    function automatic logic [QW-1:0] phys(input logic [QW-1:0] h, input logic [QCW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(p);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    tep_queue_ram #(.DEPTH(QUEUE_DEPTH), .AW(QW)) u_queue (
        .aclk(aclk), .wr_en(q_wr_en), .wr_addr(q_wr_addr), .wr_data(q_wr_data),
        .rd_en(q_rd_en), .rd_addr(q_rd_addr), .rd_data(q_rd_data)
    );

    tep_cancel_store #(.DEPTH(CANCEL_DEPTH), .AW(CW)) u_cancel (
        .aclk(aclk), .aresetn(aresetn), .rd_en(c_rd_en), .rd_addr(cidx_reg),
        .rd_id(c_rd_id), .rd_valid(c_rd_valid), .set_en(c_set_en),
        .set_addr(c_set_addr), .set_id(id_reg), .clr_en(c_clr_en),
        .clr_addr(c_clr_addr), .free_any(c_free_any), .free_addr(c_free_addr)
    );

    assign c_key   = (op_reg == OP_TICK) ? ev_id_reg : id_reg;
    assign c_hit   = c_rd_valid && (c_rd_id == c_key);
    assign sat_sum = {1'b0, ev_t_reg} + {1'b0, ev_iv_reg};

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        due_next     = due_reg;
        iv_next      = iv_reg;
        now_next     = now_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        stamp_next   = stamp_reg;
        pos_next     = pos_reg;
        ins_id_next  = ins_id_reg;
        ins_t_next   = ins_t_reg;
        ins_iv_next  = ins_iv_reg;
        ev_id_next   = ev_id_reg;
        ev_t_next    = ev_t_reg;
        ev_iv_next   = ev_iv_reg;
        cidx_next    = cidx_reg;
        n_next       = n_reg;
        em_kind_next = em_kind_reg;
        em_id_next   = em_id_reg;
        em_time_next = em_time_reg;
        em_last_next = em_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_time_next  = m_time_reg;
        m_last_next  = m_last_reg;
        q_wr_en      = 1'b0;
        q_wr_addr    = '0;
        q_wr_data    = '0;
        q_rd_en      = 1'b0;
        q_rd_addr    = '0;
        c_rd_en      = 1'b0;
        c_set_en     = 1'b0;
        c_set_addr   = c_free_addr;
        c_clr_en     = 1'b0;
        c_clr_addr   = cidx_reg;
        s_ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    id_next    = s_event_id;
                    due_next   = s_due_time;
                    iv_next    = s_repeat_interval;
                    now_next   = s_current_time;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                em_id_next   = id_reg;
                em_time_next = due_reg;
                em_last_next = 1'b1;
                ret_next     = ST_IDLE;
                state_next   = ST_EMIT;
                em_kind_next = KIND_ZERO_ID;
                case (op_reg)
                    OP_SCHEDULE: begin
                        if (id_reg == '0) begin
                            em_kind_next = KIND_ZERO_ID;
                        end else if (count_reg == QCW'(QUEUE_DEPTH)) begin
                            em_kind_next = KIND_QUEUE_FULL;
                        end else begin
                            ins_id_next = id_reg;
                            ins_t_next  = due_reg;
                            ins_iv_next = iv_reg;
                            pos_next    = count_reg;
                            state_next  = ST_IREAD;
                        end
                    end
                    OP_CANCEL: begin
                        if (id_reg != '0) begin
                            cidx_next  = '0;
                            state_next = ST_CREAD;
                        end
                    end
                    OP_TICK: begin
                        n_next     = '0;
                        state_next = ST_THEAD;
                    end
                    default: begin
                        em_kind_next = KIND_ZERO_ID;
                    end
                endcase
            end
            ST_IREAD, ST_ICMP: begin
                if (state_reg == ST_IREAD && pos_reg != '0) begin
                    q_rd_en    = 1'b1;
                    q_rd_addr  = phys(head_reg, pos_reg - QCW'(1));
                    state_next = ST_ICMP;
                end else if (state_reg == ST_ICMP && q_rd_data.due > ins_t_reg) begin
                    q_wr_en    = 1'b1;
                    q_wr_addr  = phys(head_reg, pos_reg);
                    q_wr_data  = q_rd_data;
                    pos_next   = pos_reg - QCW'(1);
                    state_next = ST_IREAD;
                end else begin
                    q_wr_en    = 1'b1;
                    q_wr_addr  = phys(head_reg, pos_reg);
                    q_wr_data  = '{due: ins_t_reg, id: ins_id_reg,
                                   interval: ins_iv_reg, stamp: stamp_reg};
                    count_next = count_reg + QCW'(1);
                    stamp_next = stamp_reg + 16'd1;
                    if (op_reg == OP_TICK) begin
                        state_next = ST_THEAD;
                    end else begin
                        em_kind_next = KIND_ACCEPTED;
                        em_id_next   = id_reg;
                        em_time_next = due_reg;
                        em_last_next = 1'b1;
                        ret_next     = ST_IDLE;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_CREAD: begin
                c_rd_en    = 1'b1;
                state_next = ST_CCMP;
            end
            ST_CCMP: begin
                if (!c_hit && cidx_reg != CW'(CANCEL_DEPTH - 1)) begin
                    cidx_next  = cidx_reg + CW'(1);
                    state_next = ST_CREAD;
                end else if (op_reg == OP_CANCEL) begin
                    em_id_next   = id_reg;
                    em_time_next = due_reg;
                    em_last_next = 1'b1;
                    ret_next     = ST_IDLE;
                    state_next   = ST_EMIT;
                    em_kind_next = KIND_ACCEPTED;
                    if (!c_hit) begin
                        if (c_free_any) begin
                            c_set_en = 1'b1;
                        end else begin
                            em_kind_next = KIND_CANCEL_FULL;
                        end
                    end
                end else begin
                    head_next  = phys(head_reg, QCW'(1));
                    count_next = count_reg - QCW'(1);
                    if (c_hit) begin
                        c_clr_en   = 1'b1;
                        state_next = ST_THEAD;
                    end else begin
                        n_next       = n_reg + NW'(1);
                        em_kind_next = KIND_FIRED;
                        em_id_next   = ev_id_reg;
                        em_time_next = ev_t_reg;
                        em_last_next = 1'b0;
                        state_next   = ST_EMIT;
                        ret_next     = ST_THEAD;
                        if (ev_iv_reg != '0) begin
                            ins_id_next = ev_id_reg;
                            ins_t_next  = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
                            ins_iv_next = ev_iv_reg;
                            pos_next    = count_reg - QCW'(1);
                            ret_next    = ST_IREAD;
                        end
                    end
                end
            end
            ST_THEAD: begin
                if (count_reg == '0 || n_reg == NW'(MAX_RESULTS_PER_TICK - 1)) begin
                    em_kind_next = KIND_TICK_DONE;
                    em_id_next   = '0;
                    em_time_next = now_reg;
                    em_last_next = 1'b1;
                    ret_next     = ST_IDLE;
                    state_next   = ST_EMIT;
                end else begin
                    q_rd_en    = 1'b1;
                    q_rd_addr  = head_reg;
                    state_next = ST_THCHK;
                end
            end
            ST_THCHK: begin
                if (q_rd_data.due <= now_reg) begin
                    ev_id_next = q_rd_data.id;
                    ev_t_next  = q_rd_data.due;
                    ev_iv_next = q_rd_data.interval;
                    cidx_next  = '0;
                    state_next = ST_CREAD;
                end else begin
                    em_kind_next = KIND_TICK_DONE;
                    em_id_next   = '0;
                    em_time_next = now_reg;
                    em_last_next = 1'b1;
                    ret_next     = ST_IDLE;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = em_kind_reg;
                    m_id_next    = em_id_reg;
                    m_time_next  = em_time_reg;
                    m_last_next  = em_last_reg;
                    state_next   = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            stamp_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            stamp_reg   <= stamp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        op_reg      <= op_next;
        id_reg      <= id_next;
        due_reg     <= due_next;
        iv_reg      <= iv_next;
        now_reg     <= now_next;
        pos_reg     <= pos_next;
        ins_id_reg  <= ins_id_next;
        ins_t_reg   <= ins_t_next;
        ins_iv_reg  <= ins_iv_next;
        ev_id_reg   <= ev_id_next;
        ev_t_reg    <= ev_t_next;
        ev_iv_reg   <= ev_iv_next;
        cidx_reg    <= cidx_next;
        n_reg       <= n_next;
        em_kind_reg <= em_kind_next;
        em_id_reg   <= em_id_next;
        em_time_reg <= em_time_next;
        em_last_reg <= em_last_next;
        m_kind_reg  <= m_kind_next;
        m_id_reg    <= m_id_next;
        m_time_reg  <= m_time_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_fired_id    = m_id_reg;
    assign m_fired_time  = m_time_reg;
    assign m_last        = m_last_reg;
endmodule
`default_nettype wire

@@ src/tep_checker.sv @@
// Port-level checks for the timed event priority scheduler, bound to the top level.
// Depends on tep_pkg for the result kind codes.
`default_nettype none
module tep_checker import tep_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_result_kind,
    input wire logic        m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result item dropped before it was taken.");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_kind <= KIND_TICK_DONE)
        else $error("Result kind out of range.");

    a_fired_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_FIRED |-> !m_last)
        else $error("Fired item marked as last.");

    a_other_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_FIRED |-> m_last)
        else $error("Final item not marked as last.");
endmodule

bind timed_event_priority_scheduler tep_checker u_tep_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_result_kind(m_result_kind), .m_last(m_last)
);
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the timed event priority scheduler.
// Drives schedule, cancel and tick items and checks every result against a local model.
// Depends on tep_pkg and timed_event_priority_scheduler.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import tep_pkg::*;

    localparam int QDEPTH = 16;
    localparam int CDEPTH = 16;
    localparam int MAX_PER_TICK = 64;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 120;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] id;
        logic [31:0] due;
        logic [31:0] interval;
        logic [31:0] now;
    } sched_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] t;
        logic        last;
    } sched_result_t;

    typedef struct {
        sched_item_t   item;
        bit            typed;
        sched_result_t res;
    } table_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [31:0] s_event_id;
    logic [31:0] s_due_time;
    logic [31:0] s_repeat_interval;
    logic [31:0] s_current_time;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_result_kind;
    logic [31:0] m_fired_id;
    logic [31:0] m_fired_time;
    logic        m_last;

    timed_event_priority_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_event_id(s_event_id),
        .s_due_time(s_due_time), .s_repeat_interval(s_repeat_interval),
        .s_current_time(s_current_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_kind(m_result_kind), .m_fired_id(m_fired_id),
        .m_fired_time(m_fired_time), .m_last(m_last)
    );

    logic [31:0] ev_due[QDEPTH];
    logic [31:0] ev_id[QDEPTH];
    logic [31:0] ev_interval[QDEPTH];
    int          ev_count;
    logic [31:0] mark_id[CDEPTH];
    bit          mark_valid[CDEPTH];

    sched_result_t pending_results[$];
    table_row_t    item_queue[$];
    int  errors;
    bit  hold_receiver;
    int  idle_cycles;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void insert_event(logic [31:0] id, logic [31:0] due,
                                         logic [31:0] interval);
        int pos;
        pos = ev_count;
        while (pos > 0 && ev_due[pos-1] > due) begin
            ev_due[pos] = ev_due[pos-1];
            ev_id[pos] = ev_id[pos-1];
            ev_interval[pos] = ev_interval[pos-1];
            pos--;
        end
        ev_due[pos] = due;
        ev_id[pos] = id;
        ev_interval[pos] = interval;
        ev_count++;
    endfunction

    function automatic int find_mark(logic [31:0] id);
        for (int i = 0; i < CDEPTH; i++)
            if (mark_valid[i] && mark_id[i] == id) return i;
        return CDEPTH;
    endfunction

    function automatic void push(logic [2:0] kind, logic [31:0] id, logic [31:0] t,
                                 logic last);
        sched_result_t r;
        r.kind = kind;
        r.id = id;
        r.t = t;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_scheduler(sched_item_t it);
        int n;
        int slot;
        logic [31:0] eid, et, eiv, nt;
        case (it.op)
            OP_SCHEDULE: begin
                if (it.id == 0) push(KIND_ZERO_ID, it.id, it.due, 1'b1);
                else if (ev_count >= QDEPTH) push(KIND_QUEUE_FULL, it.id, it.due, 1'b1);
                else begin
                    insert_event(it.id, it.due, it.interval);
                    push(KIND_ACCEPTED, it.id, it.due, 1'b1);
                end
            end
            OP_CANCEL: begin
                if (it.id == 0) push(KIND_ZERO_ID, it.id, it.due, 1'b1);
                else if (find_mark(it.id) < CDEPTH) push(KIND_ACCEPTED, it.id, it.due, 1'b1);
                else begin
                    slot = CDEPTH;
                    for (int i = 0; i < CDEPTH; i++)
                        if (!mark_valid[i] && slot == CDEPTH) slot = i;
                    if (slot < CDEPTH) begin
                        mark_valid[slot] = 1'b1;
                        mark_id[slot] = it.id;
                        push(KIND_ACCEPTED, it.id, it.due, 1'b1);
                    end else begin
                        push(KIND_CANCEL_FULL, it.id, it.due, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                n = 0;
                while (ev_count > 0 && ev_due[0] <= it.now && n < MAX_PER_TICK - 1) begin
                    eid = ev_id[0];
                    et = ev_due[0];
                    eiv = ev_interval[0];
                    slot = find_mark(eid);
                    for (int i = 1; i < ev_count; i++) begin
                        ev_due[i-1] = ev_due[i];
                        ev_id[i-1] = ev_id[i];
                        ev_interval[i-1] = ev_interval[i];
                    end
                    ev_count--;
                    if (slot < CDEPTH) begin
                        mark_valid[slot] = 1'b0;
                        continue;
                    end
                    push(KIND_FIRED, eid, et, 1'b0);
                    n++;
                    if (eiv != 0) begin
                        nt = et + eiv;
                        if (nt < et) nt = 32'hFFFF_FFFF;
                        insert_event(eid, nt, eiv);
                    end
                end
                push(KIND_TICK_DONE, 32'd0, it.now, 1'b1);
            end
            default: push(KIND_ZERO_ID, it.id, it.due, 1'b1);
        endcase
    endfunction

    function automatic sched_item_t make_item(logic [1:0] op, logic [31:0] id,
                                              logic [31:0] due, logic [31:0] interval,
                                              logic [31:0] now);
        sched_item_t it;
        it.op = op;
        it.id = id;
        it.due = due;
        it.interval = interval;
        it.now = now;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 12);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_row(table_row_t row);
        item_queue.push_back(row);
        s_valid <= 1'b1;
        s_operation <= row.item.op;
        s_event_id <= row.item.id;
        s_due_time <= row.item.due;
        s_repeat_interval <= row.item.interval;
        s_current_time <= row.item.now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_item(sched_item_t it);
        table_row_t row;
        row.item = it;
        row.typed = 1'b0;
        row.res = '0;
        send_row(row);
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0 || item_queue.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        table_row_t row;
        if (aresetn && s_valid && s_ready) begin
            if (item_queue.size() == 0) begin
                $display("%0t: unexpected input item accepted, expected none actual op=%0d",
                         $realtime, s_operation);
                errors++;
            end else begin
                row = item_queue.pop_front();
                predict_scheduler(row.item);
                if (row.typed) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(row.res);
                end
            end
        end
    end

    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d id=%h time=%h last=%b",
                         $realtime, m_result_kind, m_fired_id, m_fired_time, m_last);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $realtime, want.kind,
                             m_result_kind);
                    errors++;
                end
                if (m_fired_id !== want.id) begin
                    $display("%0t: id expected %h actual %h", $realtime, want.id,
                             m_fired_id);
                    errors++;
                end
                if (m_fired_time !== want.t) begin
                    $display("%0t: time expected %h actual %h", $realtime, want.t,
                             m_fired_time);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $realtime, want.last,
                             m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int phase;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        phase = 0;
        forever begin
            if (hold_receiver) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_receiver = 1'b0;
            end
            phase++;
            if ((phase / 40) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** timed_event_priority_scheduler: FAILED **");
            $finish;
        end
    end

    initial begin
        table_row_t rows[$];
        table_row_t row;
        sched_item_t it;
        int burst;
        int r;
        bit mid_drained;
        logic [31:0] base;

        errors = 0;
        hold_receiver = 1'b0;
        idle_cycles = 0;
        ev_count = 0;
        mid_drained = 1'b0;
        for (int i = 0; i < CDEPTH; i++) mark_valid[i] = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_SCHEDULE;
        s_event_id <= '0;
        s_due_time <= '0;
        s_repeat_interval <= '0;
        s_current_time <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        row.typed = 1'b1;
        row.item = make_item(OP_TICK, 32'h5, 32'h6, 32'h7, 32'hFFFF_FFFF);
        row.res = '{KIND_TICK_DONE, 32'd0, 32'hFFFF_FFFF, 1'b1};
        rows.push_back(row);
        row.item = make_item(OP_SCHEDULE, 32'd0, 32'h1234, 32'd0, 32'd0);
        row.res = '{KIND_ZERO_ID, 32'd0, 32'h1234, 1'b1};
        rows.push_back(row);
        row.item = make_item(OP_CANCEL, 32'd0, 32'hABCD, 32'd0, 32'd0);
        row.res = '{KIND_ZERO_ID, 32'd0, 32'hABCD, 1'b1};
        rows.push_back(row);
        row.item = make_item(2'd3, 32'h77, 32'h88, 32'h1, 32'h2);
        row.res = '{KIND_ZERO_ID, 32'h77, 32'h88, 1'b1};
        rows.push_back(row);
        row.item = make_item(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                             32'd0);
        row.res = '{KIND_ACCEPTED, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1};
        rows.push_back(row);
        row.typed = 1'b0;
        row.res = '0;
        row.item = make_item(OP_SCHEDULE, 32'd1, 32'd0, 32'd0, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_SCHEDULE, 32'd2, 32'd10, 32'd3, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_SCHEDULE, 32'd3, 32'd10, 32'd0, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_CANCEL, 32'd3, 32'd0, 32'd0, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_CANCEL, 32'd3, 32'd0, 32'd0, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd20);
        rows.push_back(row);
        row.item = make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        rows.push_back(row);
        row.item = make_item(OP_SCHEDULE, 32'd9, 32'd0, 32'd1, 32'd0);
        rows.push_back(row);
        row.item = make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd500);
        rows.push_back(row);
        row.item = make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        rows.push_back(row);

        foreach (rows[k]) send_row(rows[k]);
        drain();

        for (int i = 0; i < 17; i++) send_item(make_item(OP_SCHEDULE, 32'h100 + i,
                                                         32'hFFFF_FFFF, 32'd0, 32'd0));
        for (int i = 0; i < 17; i++) send_item(make_item(OP_CANCEL, 32'h200 + i,
                                                         32'd0, 32'd0, 32'd0));
        send_item(make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        drain();
        for (int i = 0; i < 16; i++) send_item(make_item(OP_TICK, 32'd0, 32'd0, 32'd0,
                                                         32'hFFFF_FFFF));
        drain();
        for (int i = 0; i < 16; i++) send_item(make_item(OP_SCHEDULE, 32'h200 + i,
                                                         32'd0, 32'd0, 32'd0));
        send_item(make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'd0));
        drain();

        hold_receiver = 1'b1;
        base = 32'd1000;
        r = 0;
        while (r < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && r < RANDOM_ITEMS; b++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: it = make_item(OP_SCHEDULE, $urandom_range(1, 20),
                                               base + $urandom_range(0, 60),
                                               ($urandom_range(0, 1) ? 32'd0
                                                                    : $urandom_range(1, 30)),
                                               $urandom());
                    4, 5: it = make_item(OP_CANCEL, $urandom_range(1, 20), $urandom(),
                                         $urandom(), $urandom());
                    6, 7: begin
                        base = base + $urandom_range(0, 25);
                        it = make_item(OP_TICK, $urandom(), $urandom(), $urandom(),
                                       base + $urandom_range(0, 20));
                    end
                    default: it = make_item(2'($urandom_range(0, 3)), rand_word(),
                                            rand_word(), rand_word(), rand_word());
                endcase
                send_item(it);
                r++;
            end
            if (!mid_drained && r >= RANDOM_ITEMS / 2) begin
                drain();
                mid_drained = 1'b1;
            end else begin
                idle_sender();
            end
        end
        drain();
        for (int i = 0; i < 20; i++) begin
            send_item(make_item(OP_CANCEL, $urandom_range(1, 20), 32'd0, 32'd0, 32'd0));
            send_item(make_item(OP_TICK, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        end
        drain();
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("** timed_event_priority_scheduler: PASSED **");
        else $display("** timed_event_priority_scheduler: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
